[rtl/tilt_complementary_filter_defines.svh]
// assertion macros for the tilt complementary filter
// no dependencies; included by files that carry concurrent assertions
`ifndef TILT_COMPLEMENTARY_FILTER_DEFINES_SVH
`define TILT_COMPLEMENTARY_FILTER_DEFINES_SVH
`ifndef NO_ASSERTIONS
// checked property, quiet while reset is asserted
`define TCF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// checked property, also evaluated during reset
`define TCF_ASSERT_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define TCF_ASSERT(lbl, prop, msg)
`define TCF_ASSERT_NR(lbl, prop, msg)
`endif
`endif

[rtl/tcf_pkg.sv]
// shared types, widths and the arctangent table of the tilt filter
// no dependencies; imported by tcf_cordic, tilt_complementary_filter and the testbench
package tcf_pkg;

  // field and datapath widths
  localparam int IN_W       = 16;
  localparam int OUT_W      = 16;
  localparam int ANGLE_W    = 32;
  localparam int CORDIC_W   = 35;
  localparam int MUL_A_W    = 32;
  localparam int MUL_B_W    = 18;
  localparam int PROD_W     = 50;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;
  localparam int GAIN_W     = 8;
  localparam int WEIGHT_W   = 16;
  localparam int GATE_W     = 17;
  localparam int MAG_W      = 18;
  localparam int WEIGHT_FRAC = 16;
  localparam int ATAN_DEPTH = 24;
  localparam int ATAN_IDX_W = 5;
  localparam int ATAN_FRAC  = 24;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GYRO_GAIN    = 2'd0,
    REG_ACCEL_WEIGHT = 2'd1,
    REG_GATE_LOW     = 2'd2,
    REG_GATE_HIGH    = 2'd3
  } cfg_reg_e;

  // arctangent of 2^-i in degrees, 24 fraction bits
  localparam logic [31:0] ATAN_Q24 [ATAN_DEPTH] = '{
    32'd754974720, 32'd445687602, 32'd235489088, 32'd119537938, 32'd60000934,
    32'd30029717, 32'd15018523, 32'd7509720, 32'd3754917, 32'd1877466,
    32'd938734, 32'd469367, 32'd234684, 32'd117342, 32'd58671, 32'd29335,
    32'd14668, 32'd7334, 32'd3667, 32'd1833, 32'd917, 32'd458, 32'd229, 32'd115
  };

  // cordic start request and response
  typedef struct packed {
    logic                   start;
    logic signed [IN_W-1:0] num;
    logic signed [IN_W-1:0] den;
  } cordic_req_t;

  typedef struct packed {
    logic                      done;
    logic signed [ANGLE_W-1:0] angle;
  } cordic_rsp_t;

  // table entry rounded half up to frac fraction bits
  function automatic logic signed [ANGLE_W-1:0] atan_step(input logic [ATAN_IDX_W-1:0] idx,
                                                          input int unsigned frac);
    logic [31:0] half;
    logic [31:0] r;
    half = 32'd1 << (ATAN_FRAC - 1 - frac);
    r    = (ATAN_Q24[idx] + half) >> (ATAN_FRAC - frac);
    return signed'(r);
  endfunction

endpackage

[rtl/tcf_cordic.sv]
// iterative vectoring cordic for atan2, one micro-rotation per cycle
// depends on tcf_pkg
module tcf_cordic #(
  parameter int CORDIC_STEPS    = 16,
  parameter int ANGLE_FRAC_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tcf_pkg::cordic_req_t req_i,
  output tcf_pkg::cordic_rsp_t rsp_o
);
  import tcf_pkg::*;

  localparam int ITER_W = $clog2(CORDIC_STEPS);
  localparam logic [ITER_W-1:0] LAST_ITER = ITER_W'(CORDIC_STEPS - 1);
  localparam logic signed [ANGLE_W-1:0] HALF_TURN =
    ANGLE_W'(180 * (1 << ANGLE_FRAC_BITS));

  logic                       busy_q;
  logic                       done_q;
  logic [ITER_W-1:0]          iter_q;
  logic signed [CORDIC_W-1:0] x_q, y_q;
  logic signed [ANGLE_W-1:0]  ang_q;

  logic signed [CORDIC_W-1:0] num_w, den_w, x0, y0, dx, dy;
  logic signed [ANGLE_W-1:0]  ang0, step;
  logic                       num_zero, den_neg;

  // operands scaled by 2^16, flipped into the right half plane
  assign num_zero = (req_i.num == '0);
  assign den_neg  = req_i.den[IN_W-1];
  assign num_w    = signed'({{(CORDIC_W-IN_W-16){req_i.num[IN_W-1]}}, req_i.num, 16'h0000});
  assign den_w    = signed'({{(CORDIC_W-IN_W-16){req_i.den[IN_W-1]}}, req_i.den, 16'h0000});
  assign x0       = den_neg ? -den_w : den_w;
  assign y0       = den_neg ? -num_w : num_w;

  // preloaded angle, covers the zero numerator case too
  always_comb begin
    ang0 = '0;
    if (num_zero) begin
      ang0 = den_neg ? HALF_TURN : '0;
    end else if (den_neg) begin
      ang0 = req_i.num[IN_W-1] ? -HALF_TURN : HALF_TURN;
    end
  end

  // shared shift and add for the current micro-rotation
  assign dx   = y_q >>> iter_q;
  assign dy   = x_q >>> iter_q;
  assign step = atan_step(ATAN_IDX_W'(iter_q), ANGLE_FRAC_BITS);

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      iter_q <= '0;
    end else begin
      done_q <= (!busy_q && req_i.start && num_zero) || (busy_q && (iter_q == LAST_ITER));
      if (!busy_q) begin
        if (req_i.start) begin
          iter_q <= '0;
          if (!num_zero) begin
            busy_q <= 1'b1;
          end
        end
      end else begin
        if (iter_q == LAST_ITER) begin
          busy_q <= 1'b0;
        end
        iter_q <= iter_q + 1'b1;
      end
    end
  end

  // rotation datapath
  always_ff @(posedge clk_i) begin
    if (!busy_q && req_i.start) begin
      x_q   <= x0;
      y_q   <= y0;
      ang_q <= ang0;
    end else if (busy_q) begin
      if (y_q > 0) begin
        x_q   <= x_q + dx;
        y_q   <= y_q - dy;
        ang_q <= ang_q + step;
      end else begin
        x_q   <= x_q - dx;
        y_q   <= y_q + dy;
        ang_q <= ang_q - step;
      end
    end
  end

  assign rsp_o.done  = done_q;
  assign rsp_o.angle = ang_q;

endmodule

[rtl/tilt_complementary_filter.sv]
// tilt complementary filter: gyro steps for pitch and roll, then, if the magnitude gate
// passes, cordic and blend steps for each axis (the cordic ends early on a zero numerator)
// a new sample is taken only once the last result is registered, held off while a result
// waits; the shared cordic runs atan2 twice per blended sample, one micro-rotation a cycle
// one 32x18 multiplier serves the gyro terms and the blend products
// async active-low reset: angles zero, registers at their defaults, block idle
`include "tilt_complementary_filter_defines.svh"
module tilt_complementary_filter #(
  parameter int CORDIC_STEPS    = 16,
  parameter int ANGLE_FRAC_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [tcf_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [tcf_pkg::CFG_DATA_W-1:0]       cfg_wdata_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [tcf_pkg::IN_W-1:0]      accel_x_i,
  input  logic signed [tcf_pkg::IN_W-1:0]      accel_y_i,
  input  logic signed [tcf_pkg::IN_W-1:0]      accel_z_i,
  input  logic signed [tcf_pkg::IN_W-1:0]      gyro_x_i,
  input  logic signed [tcf_pkg::IN_W-1:0]      gyro_y_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [tcf_pkg::OUT_W-1:0]     pitch_out_o,
  output logic signed [tcf_pkg::OUT_W-1:0]     roll_out_o,
  output logic                                 accel_used_o
);
  import tcf_pkg::*;

  localparam int SCALED_W = ANGLE_W + 6;
  localparam logic signed [SCALED_W-1:0] TRUNC_BIAS =
    SCALED_W'((64'd1 << ANGLE_FRAC_BITS) - 64'd1);
  localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(32768);
  localparam logic [GATE_W-1:0] FULL_WEIGHT = GATE_W'(65536);

  typedef enum logic [8:0] {
    S_IDLE       = 9'b000000001,
    S_GYRO_MUL   = 9'b000000010,
    S_GYRO_ADD   = 9'b000000100,
    S_CORD_START = 9'b000001000,
    S_CORD_WAIT  = 9'b000010000,
    S_BLEND_KEEP = 9'b000100000,
    S_BLEND_ACC  = 9'b001000000,
    S_BLEND_SAT  = 9'b010000000,
    S_OUT        = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  logic [GAIN_W-1:0]   gyro_gain_q;
  logic [WEIGHT_W-1:0] accel_weight_q;
  logic [GATE_W-1:0]   gate_low_q, gate_high_q;

  logic signed [IN_W-1:0]    ax_q, ay_q, az_q, gx_q, gy_q;
  logic                      used_q, axis_q;
  logic signed [ANGLE_W-1:0] pitch_q, roll_q, acc_q;
  logic signed [PROD_W-1:0]  mul_q, sum_q;

  logic signed [OUT_W-1:0] pitch_out_q, roll_out_q;
  logic                    used_out_q, out_valid_q;

  logic                      in_fire, out_free;
  logic [MAG_W-1:0]          mag_w;
  logic                      gate_pass;
  logic signed [ANGLE_W-1:0] cur_angle, new_angle;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod_w, gyro_sum, blend_sum;
  logic                      angle_we;
  cordic_req_t               cordic_req;
  cordic_rsp_t               cordic_rsp;

  // magnitude of one axis sample
  function automatic logic [IN_W:0] abs_axis(input logic signed [IN_W-1:0] v);
    logic signed [IN_W:0] e;
    e = {v[IN_W-1], v};
    return v[IN_W-1] ? (IN_W+1)'(0) - e : e;
  endfunction

  // clamp to the signed 32-bit angle range
  function automatic logic signed [ANGLE_W-1:0] sat_angle(input logic signed [PROD_W-1:0] v);
    logic [PROD_W-ANGLE_W:0] top;
    top = v[PROD_W-1:ANGLE_W-1];
    if (&top || ~|top) begin
      return v[ANGLE_W-1:0];
    end
    return v[PROD_W-1] ? {1'b1, {(ANGLE_W-1){1'b0}}} : {1'b0, {(ANGLE_W-1){1'b1}}};
  endfunction

  // degrees times 40, truncated toward zero, clamped to 16 bits
  function automatic logic signed [OUT_W-1:0] to_out(input logic signed [ANGLE_W-1:0] a);
    logic signed [SCALED_W-1:0] t;
    logic signed [SCALED_W-1:0] q;
    logic [SCALED_W-OUT_W:0]    top;
    t = (SCALED_W'(a) <<< 5) + (SCALED_W'(a) <<< 3);
    if (t < 0) begin
      t = t + TRUNC_BIAS;
    end
    q   = t >>> ANGLE_FRAC_BITS;
    top = q[SCALED_W-1:OUT_W-1];
    if (&top || ~|top) begin
      return q[OUT_W-1:0];
    end
    return q[SCALED_W-1] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
  endfunction

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // magnitude gate, evaluated on the incoming sample
  assign mag_w = MAG_W'(abs_axis(accel_x_i)) + MAG_W'(abs_axis(accel_y_i))
               + MAG_W'(abs_axis(accel_z_i));
  assign gate_pass = (mag_w > MAG_W'(gate_low_q)) && (mag_w < MAG_W'(gate_high_q));

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gyro_gain_q    <= GAIN_W'(10);
      accel_weight_q <= WEIGHT_W'(1311);
      gate_low_q     <= GATE_W'(8192);
      gate_high_q    <= GATE_W'(32768);
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_GYRO_GAIN:    gyro_gain_q    <= cfg_wdata_i[GAIN_W-1:0];
        REG_ACCEL_WEIGHT: accel_weight_q <= cfg_wdata_i[WEIGHT_W-1:0];
        REG_GATE_LOW:     gate_low_q     <= cfg_wdata_i[GATE_W-1:0];
        REG_GATE_HIGH:    gate_high_q    <= cfg_wdata_i[GATE_W-1:0];
        default: ;
      endcase
    end
  end

  assign cur_angle = axis_q ? roll_q : pitch_q;

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_GYRO_MUL: begin
        mul_a = signed'(MUL_A_W'(gyro_gain_q));
        mul_b = axis_q ? MUL_B_W'(gy_q) : MUL_B_W'(gx_q);
      end
      S_BLEND_KEEP: begin
        mul_a = cur_angle;
        mul_b = signed'({1'b0, FULL_WEIGHT - GATE_W'(accel_weight_q)});
      end
      S_BLEND_ACC: begin
        mul_a = acc_q;
        mul_b = signed'({2'b00, accel_weight_q});
      end
      default: ;
    endcase
  end

  assign prod_w = mul_a * mul_b;

  // gyro integration and blend result, both clamped
  assign gyro_sum  = PROD_W'(cur_angle) + (axis_q ? -mul_q : mul_q);
  assign blend_sum = (sum_q + mul_q) >>> WEIGHT_FRAC;
  assign new_angle = (state_q == S_GYRO_ADD) ? sat_angle(gyro_sum) : sat_angle(blend_sum);
  assign angle_we  = (state_q == S_GYRO_ADD) || (state_q == S_BLEND_SAT);

  // cordic request
  assign cordic_req.start = (state_q == S_CORD_START);
  assign cordic_req.num   = axis_q ? ax_q : ay_q;
  assign cordic_req.den   = az_q;

  tcf_cordic #(
    .CORDIC_STEPS    (CORDIC_STEPS),
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (cordic_req),
    .rsp_o  (cordic_rsp)
  );

  // sequencer next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:       if (in_fire) state_d = S_GYRO_MUL;
      S_GYRO_MUL:   state_d = S_GYRO_ADD;
      S_GYRO_ADD: begin
        if (!axis_q) begin
          state_d = S_GYRO_MUL;
        end else begin
          state_d = used_q ? S_CORD_START : S_OUT;
        end
      end
      S_CORD_START: state_d = S_CORD_WAIT;
      S_CORD_WAIT:  if (cordic_rsp.done) state_d = S_BLEND_KEEP;
      S_BLEND_KEEP: state_d = S_BLEND_ACC;
      S_BLEND_ACC:  state_d = S_BLEND_SAT;
      S_BLEND_SAT:  state_d = axis_q ? S_OUT : S_CORD_START;
      S_OUT:        if (out_free) state_d = S_IDLE;
      default:      state_d = S_IDLE;
    endcase
  end

  // control state and kept angles
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      used_q  <= 1'b0;
      axis_q  <= 1'b0;
      pitch_q <= '0;
      roll_q  <= '0;
    end else begin
      state_q <= state_d;
      if (in_fire) begin
        used_q <= gate_pass;
        axis_q <= 1'b0;
      end else if (state_q == S_GYRO_ADD || state_q == S_BLEND_SAT) begin
        axis_q <= !axis_q;
      end
      if (angle_we) begin
        if (axis_q) begin
          roll_q <= new_angle;
        end else begin
          pitch_q <= new_angle;
        end
      end
    end
  end

  // sample and product registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      ax_q <= accel_x_i;
      ay_q <= accel_y_i;
      az_q <= accel_z_i;
      gx_q <= gyro_x_i;
      gy_q <= gyro_y_i;
    end
    if (state_q == S_CORD_WAIT && cordic_rsp.done) begin
      acc_q <= cordic_rsp.angle;
    end
    if (state_q == S_GYRO_MUL || state_q == S_BLEND_KEEP || state_q == S_BLEND_ACC) begin
      mul_q <= prod_w;
    end
    if (state_q == S_BLEND_ACC) begin
      sum_q <= mul_q + ROUND_HALF;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == S_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_OUT && out_free) begin
      pitch_out_q <= to_out(pitch_q);
      roll_out_q  <= to_out(roll_q);
      used_out_q  <= used_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pitch_out_o  = pitch_out_q;
  assign roll_out_o   = roll_out_q;
  assign accel_used_o = used_out_q;

  // checks
  `TCF_ASSERT(a_busy_after_transfer, in_fire |=> !in_ready_o, "ready right after input transfer")
  `TCF_ASSERT(a_cordic_only_gated, cordic_req.start |-> used_q, "cordic started without gate pass")
  `TCF_ASSERT(a_cordic_done_in_wait, cordic_rsp.done |-> (state_q == S_CORD_WAIT), "cordic done outside wait")
  `TCF_ASSERT(a_out_stall_holds, (state_q == S_OUT && !out_free) |=> (state_q == S_OUT), "left output step while result pending")

endmodule

[test/tilt_complementary_filter_tb.sv]
// self-checking testbench for tilt_complementary_filter: random and directed sensor samples,
// with every result checked against a cycle-free fixed-point model of the pitch/roll filter
// depends on tcf_pkg and the tilt_complementary_filter rtl only
`timescale 1ns / 100ps

module tilt_complementary_filter_tb;
  import tcf_pkg::*;

  localparam int CORDIC_STEPS    = 16;
  localparam int ANGLE_FRAC_BITS = 16;
  localparam int WATCHDOG_LIMIT  = 1000;
  localparam int END_SETTLE      = 60;
  localparam int CFG_SETTLE      = 4;
  localparam int RANDOM_ITEMS    = 25;
  localparam longint HALF_TURN   = 180 * (longint'(1) << ANGLE_FRAC_BITS);

  // arctangent of 2^-i in degrees, 24 fraction bits
  localparam longint ATAN_DEG_Q24 [24] = '{
    754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
    15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684, 117342,
    58671, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115
  };

  typedef struct {
    logic signed [IN_W-1:0] ax;
    logic signed [IN_W-1:0] ay;
    logic signed [IN_W-1:0] az;
    logic signed [IN_W-1:0] gx;
    logic signed [IN_W-1:0] gy;
  } tilt_sample_t;

  typedef struct {
    logic signed [OUT_W-1:0] pitch;
    logic signed [OUT_W-1:0] roll;
    logic                    used;
  } tilt_result_t;

  // clock, reset and dut ports
  logic                    clk_i       = 1'b0;
  logic                    rst_ni      = 1'b0;
  logic                    cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]   cfg_wdata_i = '0;
  logic                    in_valid_i  = 1'b0;
  logic                    in_ready_o;
  logic signed [IN_W-1:0]  accel_x_i   = '0;
  logic signed [IN_W-1:0]  accel_y_i   = '0;
  logic signed [IN_W-1:0]  accel_z_i   = '0;
  logic signed [IN_W-1:0]  gyro_x_i    = '0;
  logic signed [IN_W-1:0]  gyro_y_i    = '0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic signed [OUT_W-1:0] pitch_out_o;
  logic signed [OUT_W-1:0] roll_out_o;
  logic                    accel_used_o;

  // filter state and register copies, at their reset values
  logic signed [ANGLE_W-1:0] pitch_deg_q  = '0;
  logic signed [ANGLE_W-1:0] roll_deg_q   = '0;
  logic [GAIN_W-1:0]         gyro_gain_q  = 8'd10;
  logic [WEIGHT_W-1:0]       accel_wt_q   = 16'd1311;
  logic [GATE_W-1:0]         gate_low_q   = 17'd8192;
  logic [GATE_W-1:0]         gate_high_q  = 17'd32768;

  tilt_result_t expected_tilt_q [$];
  tilt_result_t want_r;
  int           errors      = 0;
  int           idle_cycles = 0;
  bit           no_idle     = 1'b0;

  tilt_complementary_filter #(
    .CORDIC_STEPS   (CORDIC_STEPS),
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .accel_x_i   (accel_x_i),
    .accel_y_i   (accel_y_i),
    .accel_z_i   (accel_z_i),
    .gyro_x_i    (gyro_x_i),
    .gyro_y_i    (gyro_y_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .pitch_out_o (pitch_out_o),
    .roll_out_o  (roll_out_o),
    .accel_used_o(accel_used_o)
  );

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // fixed-point filter arithmetic
  // ---------------------------------------------------------------------------

  function automatic logic signed [ANGLE_W-1:0] clamp_angle(input longint v);
    if (v > longint'(32'sh7fffffff)) return 32'sh7fffffff;
    if (v < -longint'(32'sh7fffffff) - 1) return 32'sh80000000;
    return v[ANGLE_W-1:0];
  endfunction

  function automatic longint magnitude_of(input logic signed [IN_W-1:0] v);
    return (v < 0) ? -longint'(v) : longint'(v);
  endfunction

  // vectoring cordic atan2(num, den), degrees with ANGLE_FRAC_BITS fraction bits
  function automatic longint accel_angle(input logic signed [IN_W-1:0] num,
                                         input logic signed [IN_W-1:0] den);
    longint x;
    longint y;
    longint ang;
    longint dx;
    longint dy;
    longint step;
    x   = longint'(den) * 65536;
    y   = longint'(num) * 65536;
    ang = 0;
    // zero numerator: straight ahead or straight behind
    if (num == 0) return (den < 0) ? HALF_TURN : 0;
    // left half plane: rotate by half a turn first
    if (den < 0) begin
      ang = (num >= 0) ? HALF_TURN : -HALF_TURN;
      x   = -x;
      y   = -y;
    end
    for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
      step = (ATAN_DEG_Q24[i] + (longint'(1) << (23 - ANGLE_FRAC_BITS)))
             >> (24 - ANGLE_FRAC_BITS);
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x   = x + dx;
        y   = y - dy;
        ang = ang + step;
      end else begin
        x   = x - dx;
        y   = y + dy;
        ang = ang - step;
      end
    end
    return ang;
  endfunction

  function automatic logic signed [ANGLE_W-1:0] blend_angle(input logic signed [ANGLE_W-1:0] kept,
                                                            input longint acc);
    longint w;
    longint sum;
    w   = longint'(accel_wt_q);
    sum = longint'(kept) * (65536 - w) + acc * w + 32768;
    return clamp_angle(sum >>> WEIGHT_FRAC);
  endfunction

  // degrees times 40, truncated toward zero, saturated to 16 bits
  function automatic logic signed [OUT_W-1:0] scaled_output(input logic signed [ANGLE_W-1:0] a);
    longint q;
    q = (longint'(a) * 40) / (longint'(1) << ANGLE_FRAC_BITS);
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[OUT_W-1:0];
  endfunction

  // advance the filter state by one sample and return the output it gives
  function automatic tilt_result_t filter_sample(input tilt_sample_t s);
    tilt_result_t r;
    longint       mag;
    pitch_deg_q = clamp_angle(longint'(pitch_deg_q) + longint'(gyro_gain_q) * longint'(s.gx));
    roll_deg_q  = clamp_angle(longint'(roll_deg_q) - longint'(gyro_gain_q) * longint'(s.gy));
    mag    = magnitude_of(s.ax) + magnitude_of(s.ay) + magnitude_of(s.az);
    r.used = (mag > longint'(gate_low_q)) && (mag < longint'(gate_high_q));
    if (r.used) begin
      pitch_deg_q = blend_angle(pitch_deg_q, accel_angle(s.ay, s.az));
      roll_deg_q  = blend_angle(roll_deg_q, accel_angle(s.ax, s.az));
    end
    r.pitch = scaled_output(pitch_deg_q);
    r.roll  = scaled_output(roll_deg_q);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic int draw_gap();
    return no_idle ? 0 : int'($urandom_range(0, 6));
  endfunction

  function automatic tilt_sample_t sample(input int ax, input int ay, input int az,
                                          input int gx, input int gy);
    tilt_sample_t s;
    s.ax = ax[IN_W-1:0];
    s.ay = ay[IN_W-1:0];
    s.az = az[IN_W-1:0];
    s.gx = gx[IN_W-1:0];
    s.gy = gy[IN_W-1:0];
    return s;
  endfunction

  function automatic int signed_upto(input int unsigned n);
    return int'($urandom_range(0, 2 * n)) - int'(n);
  endfunction

  function automatic int extreme_value();
    case ($urandom_range(0, 4))
      0: return -32768;
      1: return -1;
      2: return 0;
      3: return 1;
      default: return 32767;
    endcase
  endfunction

  // mostly plausible still-ish samples so blending is reached, plus noise
  function automatic tilt_sample_t draw_sample();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5:
        return sample(signed_upto(12000), signed_upto(12000), signed_upto(16000),
                      signed_upto(2000), signed_upto(2000));
      6, 7:
        return sample(signed_upto(32768), signed_upto(32768), signed_upto(32768),
                      signed_upto(32768), signed_upto(32768));
      8:
        return sample(extreme_value(), extreme_value(), extreme_value(),
                      extreme_value(), extreme_value());
      default:
        // zero numerator on one or both atan2 operands
        return sample($urandom_range(0, 1) ? 0 : signed_upto(15000),
                      $urandom_range(0, 1) ? 0 : signed_upto(15000),
                      $urandom_range(0, 1) ? 0 : signed_upto(20000),
                      signed_upto(500), signed_upto(500));
    endcase
  endfunction

  // one sample transfer; expectation queued at the accepting edge
  task automatic send_sample(input tilt_sample_t s);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    accel_x_i  <= s.ax;
    accel_y_i  <= s.ay;
    accel_z_i  <= s.az;
    gyro_x_i   <= s.gx;
    gyro_y_i   <= s.gy;
    do @(posedge clk_i); while (!in_ready_o);
    expected_tilt_q.push_back(filter_sample(s));
  endtask

  // stop sending and wait for every outstanding result
  task automatic drain_results(input int settle);
    in_valid_i <= 1'b0;
    while (expected_tilt_q.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (idx)
      REG_GYRO_GAIN:    gyro_gain_q = data[GAIN_W-1:0];
      REG_ACCEL_WEIGHT: accel_wt_q  = data[WEIGHT_W-1:0];
      REG_GATE_LOW:     gate_low_q  = data[GATE_W-1:0];
      REG_GATE_HIGH:    gate_high_q = data[GATE_W-1:0];
      default: ;
    endcase
  endtask

  // all four registers, only with the block idle
  task automatic program_filter(input int gain, input int weight, input int lo, input int hi);
    drain_results(CFG_SETTLE);
    write_reg(REG_GYRO_GAIN, gain[CFG_DATA_W-1:0]);
    write_reg(REG_ACCEL_WEIGHT, weight[CFG_DATA_W-1:0]);
    write_reg(REG_GATE_LOW, lo[CFG_DATA_W-1:0]);
    write_reg(REG_GATE_HIGH, hi[CFG_DATA_W-1:0]);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset register values, atan2 corner cases, gate edges and field extremes
  task automatic test_directed();
    send_sample(sample(0, 0, 0, 0, 0));
    send_sample(sample(0, 0, 16384, 0, 0));
    send_sample(sample(0, 0, -16384, 0, 0));
    send_sample(sample(-10000, 10000, -10000, 100, -100));
    send_sample(sample(10000, -10000, -10000, -100, 100));
    send_sample(sample(12000, 0, 0, 0, 0));
    send_sample(sample(-12000, -9000, 0, 0, 0));
    send_sample(sample(3000, 4000, 5000, 300, -300));
    send_sample(sample(8192, 0, 0, 0, 0));
    send_sample(sample(8193, 0, 0, 0, 0));
    send_sample(sample(-32768, 0, 0, 0, 0));
    send_sample(sample(32767, 0, 0, 0, 0));
    send_sample(sample(0, 32767, -1, 0, 0));
    send_sample(sample(0, 0, 0, 32767, -32768));
    send_sample(sample(0, 0, 0, -32768, 32767));
    send_sample(sample(-32768, -32768, -32768, 0, 0));
    send_sample(sample(32767, 32767, 32767, 32767, 32767));
    send_sample(sample(1, -1, 1, -1, 1));
    send_sample(sample(20000, 1, -1, 0, 0));
    send_sample(sample(-20000, -1, -1, 0, 0));
    drain_results(CFG_SETTLE);
  endtask

  // widest gate and both weight extremes
  task automatic test_gate_extremes();
    program_filter(0, 65535, 0, 98304);
    send_sample(sample(0, 0, 0, 1000, 1000));
    send_sample(sample(1, 0, 0, 0, 0));
    send_sample(sample(-32768, -32768, 32767, 0, 0));
    send_sample(sample(-32768, -32768, -32768, 0, 0));
    send_sample(sample(5, 3, -3, 0, 0));
    send_sample(sample(-7, -3, 9, 0, 0));
    program_filter(255, 0, 8192, 32768);
    send_sample(sample(0, 10000, 10000, 32767, -32768));
    send_sample(sample(-5000, 0, -10000, 0, 0));
    send_sample(sample(0, 0, 0, -32768, 32767));
  endtask

  // low limit at or above the high limit never blends
  task automatic test_gate_crossed();
    program_filter(37, 40000, 30000, 10000);
    send_sample(sample(10000, 5000, 5000, 50, 50));
    send_sample(sample(2000, 2000, 1000, 0, 0));
    send_sample(sample(20000, 10000, 10000, 0, 0));
    program_filter(37, 40000, 20000, 20000);
    send_sample(sample(10000, 5000, 5000, 0, 0));
    send_sample(sample(10000, 5000, 5001, 0, 0));
  endtask

  // drive both angles into the 32-bit limits, then blend from there
  task automatic test_angle_saturation();
    program_filter(255, 32768, 0, 98304);
    no_idle = 1'b1;
    for (int i = 0; i < 264; i++) send_sample(sample(0, 0, 0, 32767, 32767));
    no_idle = 1'b0;
    send_sample(sample(0, 0, 16384, 32767, 32767));
    send_sample(sample(100, -100, -16384, 32767, 32767));
    send_sample(sample(0, 0, 0, -32768, -32768));
    send_sample(sample(-9000, 9000, 9000, 0, 0));
  endtask

  // random samples over several register settings, with drain pauses
  task automatic test_random_traffic();
    int lo;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: program_filter(10, 1311, 8192, 32768);
        1: begin
          lo = $urandom_range(0, 20000);
          program_filter($urandom_range(0, 255), $urandom_range(0, 65535), lo,
                         lo + int'($urandom_range(5000, 60000)));
        end
        2: program_filter(1, 65535, 0, 98304);
        default: program_filter($urandom_range(0, 255), $urandom_range(0, 65535),
                                $urandom_range(0, 98304), $urandom_range(0, 98304));
      endcase
      no_idle = (phase == 2);
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
        if ((phase == 0 && i == RANDOM_ITEMS / 2) || $urandom_range(0, 39) == 0) begin
          drain_results(0);
        end
        send_sample(draw_sample());
      end
    end
    no_idle = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // result side: ready stalls, checking and watchdog
  // ---------------------------------------------------------------------------

  // random ready stalls per result, ready held high when the draw is zero
  initial begin : result_ready
    int stall;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // compare every result transfer with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_tilt_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual pitch %0d roll %0d used %0b",
                 $time, pitch_out_o, roll_out_o, accel_used_o);
        errors++;
      end else begin
        want_r = expected_tilt_q.pop_front();
        if (pitch_out_o !== want_r.pitch) begin
          $display("%0t: pitch_out expected %0d, actual %0d", $time, want_r.pitch, pitch_out_o);
          errors++;
        end
        if (roll_out_o !== want_r.roll) begin
          $display("%0t: roll_out expected %0d, actual %0d", $time, want_r.roll, roll_out_o);
          errors++;
        end
        if (accel_used_o !== want_r.used) begin
          $display("%0t: accel_used expected %0b, actual %0b", $time, want_r.used,
                   accel_used_o);
          errors++;
        end
      end
    end
  end

  // ends the run after too long without any transfer
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_gate_extremes();
    test_gate_crossed();
    test_angle_saturation();
    test_random_traffic();
    drain_results(END_SETTLE);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
